@@ design/hsv2rgb_pkg.sv @@
// Shared types and constants for the HSV to RGB pixel converter.
// No dependencies; imported by hsv2rgb_shade and hsv_to_rgb_converter_unit.
package hsv2rgb_pkg;

    localparam int ChanW = 8;
    localparam int PosW  = 11;    // sextant position 0..1530

    // hue*257*1530 folded into one constant multiplier
    localparam logic [18:0] PosScale = 19'd393210;
    localparam logic [26:0] PosRound = 27'd32768;

    localparam logic [PosW-1:0] SegOne   = 11'd255;
    localparam logic [PosW-1:0] SegTwo   = 11'd510;
    localparam logic [PosW-1:0] SegThree = 11'd765;
    localparam logic [PosW-1:0] SegFour  = 11'd1020;
    localparam logic [PosW-1:0] SegFive  = 11'd1275;
    localparam logic [PosW-1:0] SextantSpan = 11'd1530;

    localparam logic [ChanW-1:0] ChanMax = 8'd255;

    // load enables for the two shading stages
    typedef struct packed {
        logic en_mul;
        logic en_out;
    } t_shade_ctl;

endpackage

@@ design/hsv2rgb_shade.sv @@
// Two-stage saturation and value shading of one base channel level.
// Depends on hsv2rgb_pkg.
module hsv2rgb_shade
    import hsv2rgb_pkg::*;
(
    input  logic             i_clk,
    input  t_shade_ctl       i_ctl,
    input  logic [ChanW-1:0] i_base,
    input  logic [ChanW-1:0] i_sat,
    input  logic [ChanW-1:0] i_val,
    output logic [ChanW-1:0] o_chan
);

    logic [9:0]       r_t;
    logic [9:0]       n_t;
    logic [ChanW-1:0] r_val;
    logic [ChanW-1:0] r_chan;
    logic [ChanW-1:0] n_chan;
    logic [16:0]      sat_prod;
    logic [18:0]      val_prod;

    always_comb begin
        sat_prod = 17'(i_base) * (17'(i_sat) + 17'd1);
        n_t      = 10'(sat_prod[16:8]) + 10'(ChanMax - i_sat);
        val_prod = 19'(r_t) * (19'(r_val) + 19'd1);
        // keep the low byte of the shifted product
        n_chan   = val_prod[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_t   <= n_t;
            r_val <= i_val;
        end
        if (i_ctl.en_out) begin
            r_chan <= n_chan;
        end
    end

    assign o_chan = r_chan;

endmodule

@@ design/hsv_to_rgb_converter_unit.sv @@
// HSV to RGB converter: 8-bit hue, saturation, value in; 8-bit red, green, blue out.
// Every stage is registered; one beat per cycle sustained while the output is not stalled.
// Stages: hue scaling multiply, sextant ramps, saturation multiply, value multiply.
// A stalled output holds its beat while earlier stages keep filling any bubbles.
// Synchronous active-low reset clears all stage valid bits; payload is not reset.
// Depends on hsv2rgb_pkg and hsv2rgb_shade.
module hsv_to_rgb_converter_unit
    import hsv2rgb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [ChanW-1:0] i_hue_in,
    input  logic [ChanW-1:0] i_sat_in,
    input  logic [ChanW-1:0] i_val_in,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [ChanW-1:0] o_red_out,
    output logic [ChanW-1:0] o_green_out,
    output logic [ChanW-1:0] o_blue_out
);

    logic [3:0]       r_vld;
    logic [3:0]       en;

    logic [PosW-1:0]  r_pos;
    logic [PosW-1:0]  n_pos;
    logic [ChanW-1:0] r_sat1;
    logic [ChanW-1:0] r_val1;

    logic [ChanW-1:0] r_red;
    logic [ChanW-1:0] r_green;
    logic [ChanW-1:0] r_blue;
    logic [ChanW-1:0] n_red;
    logic [ChanW-1:0] n_green;
    logic [ChanW-1:0] n_blue;
    logic [ChanW-1:0] r_sat2;
    logic [ChanW-1:0] r_val2;

    logic [26:0]      hue_prod;
    logic [PosW-1:0]  ramp_down;
    logic [PosW-1:0]  ramp_up;
    t_shade_ctl       shade_ctl;

    // a stage loads when it is empty or its contents move on
    assign en[3]   = !r_vld[3] || i_ready;
    assign en[2]   = !r_vld[2] || en[3];
    assign en[1]   = !r_vld[1] || en[2];
    assign en[0]   = !r_vld[0] || en[1];
    assign o_ready = en[0];
    assign o_valid = r_vld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            if (en[1]) r_vld[1] <= r_vld[0];
            if (en[2]) r_vld[2] <= r_vld[1];
            if (en[3]) r_vld[3] <= r_vld[2];
        end
    end

    // stage 1: scale hue to sextant position, rounding halves up
    always_comb begin
        hue_prod = 27'(i_hue_in) * 27'(PosScale);
        n_pos    = PosW'((hue_prod + PosRound) >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_pos  <= n_pos;
            r_sat1 <= i_sat_in;
            r_val1 <= i_val_in;
        end
    end

    // stage 2: piecewise-linear ramps
    always_comb begin
        n_red     = ChanMax;
        n_green   = '0;
        n_blue    = '0;
        ramp_down = '0;
        ramp_up   = '0;
        if (r_pos < SegTwo) begin
            ramp_down = SegTwo - r_pos;
            if (r_pos < SegOne) begin
                n_green = ChanW'(r_pos);
            end else begin
                n_red   = ChanW'(ramp_down);
                n_green = ChanMax;
            end
        end else if (r_pos < SegFour) begin
            n_red     = '0;
            ramp_up   = r_pos - SegTwo;
            ramp_down = SegFour - r_pos;
            if (r_pos < SegThree) begin
                n_green = ChanMax;
                n_blue  = ChanW'(ramp_up);
            end else begin
                n_green = ChanW'(ramp_down);
                n_blue  = ChanMax;
            end
        end else if (r_pos < SextantSpan) begin
            ramp_up   = r_pos - SegFour;
            ramp_down = SextantSpan - r_pos;
            if (r_pos < SegFive) begin
                n_red  = ChanW'(ramp_up);
                n_blue = ChanMax;
            end else begin
                n_blue = ChanW'(ramp_down);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_sat2  <= r_sat1;
            r_val2  <= r_val1;
        end
    end

    // stages 3 and 4: shade each channel by saturation, then value
    assign shade_ctl.en_mul = en[2];
    assign shade_ctl.en_out = en[3];

    hsv2rgb_shade u_shade_red (
        .i_clk  (i_clk),
        .i_ctl  (shade_ctl),
        .i_base (r_red),
        .i_sat  (r_sat2),
        .i_val  (r_val2),
        .o_chan (o_red_out)
    );

    hsv2rgb_shade u_shade_green (
        .i_clk  (i_clk),
        .i_ctl  (shade_ctl),
        .i_base (r_green),
        .i_sat  (r_sat2),
        .i_val  (r_val2),
        .o_chan (o_green_out)
    );

    hsv2rgb_shade u_shade_blue (
        .i_clk  (i_clk),
        .i_ctl  (shade_ctl),
        .i_base (r_blue),
        .i_sat  (r_sat2),
        .i_val  (r_val2),
        .o_chan (o_blue_out)
    );

endmodule

@@ dv/hsv_to_rgb_converter_unit_tb.sv @@
// Self-checking testbench for hsv_to_rgb_converter_unit: directed and random HSV pixels,
// with each RGB result predicted in the bench. Depends on hsv2rgb_pkg and the unit's RTL.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_unit_tb
    import hsv2rgb_pkg::*;
();

    localparam int ClkHalf    = 10;
    localparam int ResetCyc   = 12;
    localparam int DrainCyc   = 10;
    localparam int CycleLimit = 200000;
    localparam int PhaseItems = 262;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
    } t_rgb_pixel;

    typedef struct {
        logic [ChanW-1:0] hue;
        logic [ChanW-1:0] sat;
        logic [ChanW-1:0] val;
        int unsigned      idle_pct;
        int unsigned      stall_pct;
        bit               pause;
    } t_hsv_beat;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic             i_ready     = 1'b0;
    logic [ChanW-1:0] i_hue_in    = '0;
    logic [ChanW-1:0] i_sat_in    = '0;
    logic [ChanW-1:0] i_val_in    = '0;
    logic             o_ready;
    logic             o_valid;
    logic [ChanW-1:0] o_red_out;
    logic [ChanW-1:0] o_green_out;
    logic [ChanW-1:0] o_blue_out;

    t_hsv_beat   hsv_pending_q[$];
    t_rgb_pixel  rgb_expect_q[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          in_beat_taken  = 1'b0;
    bit          drain_hold     = 1'b0;
    int unsigned stall_pct      = 0;

    hsv_to_rgb_converter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_hue_in    (i_hue_in),
        .i_sat_in    (i_sat_in),
        .i_val_in    (i_val_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

    initial begin
        forever #(ClkHalf) i_clk = ~i_clk;
    end

    initial begin
        repeat (ResetCyc) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Scale a base level by saturation, then by value; keep the low byte.
    function automatic logic [ChanW-1:0] shade_level(input int unsigned base,
                                                     input int unsigned sat,
                                                     input int unsigned val);
        int unsigned lvl;
        lvl = ((base * (sat + 1)) >> 8) + (255 - sat);
        return ChanW'((lvl * (val + 1)) >> 8);
    endfunction

    function automatic t_rgb_pixel hsv_pixel_color(input logic [ChanW-1:0] hue,
                                                   input logic [ChanW-1:0] sat,
                                                   input logic [ChanW-1:0] val);
        int unsigned pos;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        t_rgb_pixel  px;
        // widen hue to 16 bits, then round onto the 0..1530 circle
        pos = ({24'd0, hue} * 32'd257 * 32'd1530 + 32'd32768) >> 16;
        if (pos < SegTwo) begin
            b = 0;
            if (pos < SegOne) begin
                r = 255;
                g = pos;
            end else begin
                r = 510 - pos;
                g = 255;
            end
        end else if (pos < SegFour) begin
            r = 0;
            if (pos < SegThree) begin
                g = 255;
                b = pos - 510;
            end else begin
                g = 1020 - pos;
                b = 255;
            end
        end else if (pos < SextantSpan) begin
            g = 0;
            if (pos < SegFive) begin
                r = pos - 1020;
                b = 255;
            end else begin
                r = 255;
                b = 1530 - pos;
            end
        end else begin
            // top of the circle wraps to pure red
            r = 255;
            g = 0;
            b = 0;
        end
        px.red   = shade_level(r, sat, val);
        px.green = shade_level(g, sat, val);
        px.blue  = shade_level(b, sat, val);
        return px;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic queue_pixel(input logic [ChanW-1:0] hue, input logic [ChanW-1:0] sat,
                               input logic [ChanW-1:0] val, input int unsigned idle_pct,
                               input int unsigned stall);
        t_hsv_beat bt;
        bt.hue       = hue;
        bt.sat       = sat;
        bt.val       = val;
        bt.idle_pct  = idle_pct;
        bt.stall_pct = stall;
        bt.pause     = 1'b0;
        hsv_pending_q.push_back(bt);
    endtask

    task automatic queue_pause();
        t_hsv_beat bt;
        bt = '{default: 0};
        bt.pause = 1'b1;
        hsv_pending_q.push_back(bt);
    endtask

    // Bias toward the field extremes now and then.
    function automatic logic [ChanW-1:0] pick_byte();
        int unsigned roll;
        roll = $urandom_range(7);
        if (roll == 0) return '0;
        if (roll == 1) return ChanMax;
        return ChanW'($urandom_range(255));
    endfunction

    initial begin : stimulus_fill
        int unsigned idle_mode[4];
        int unsigned stall_mode[4];
        idle_mode  = '{0, 67, 0, 13};
        stall_mode = '{0, 0, 67, 13};

        // hue corners and sextant boundaries, full saturation and value
        queue_pixel(8'd0,   8'd255, 8'd255, 0, 0);
        queue_pixel(8'd42,  8'd255, 8'd255, 0, 0);
        queue_pixel(8'd43,  8'd255, 8'd255, 0, 0);
        queue_pixel(8'd85,  8'd255, 8'd255, 0, 0);
        queue_pixel(8'd127, 8'd255, 8'd255, 0, 0);
        queue_pixel(8'd128, 8'd255, 8'd255, 0, 0);
        queue_pixel(8'd170, 8'd255, 8'd255, 0, 0);
        queue_pixel(8'd212, 8'd255, 8'd255, 0, 0);
        queue_pixel(8'd213, 8'd255, 8'd255, 0, 0);
        queue_pixel(8'd254, 8'd255, 8'd255, 0, 0);
        // top of the hue circle lands on pure red
        queue_pixel(8'd255, 8'd255, 8'd255, 0, 0);
        // saturation and value extremes
        queue_pixel(8'd0,   8'd0,   8'd0,   0, 0);
        queue_pixel(8'd255, 8'd0,   8'd0,   0, 0);
        queue_pixel(8'd0,   8'd0,   8'd255, 0, 0);
        queue_pixel(8'd255, 8'd255, 8'd0,   0, 0);
        queue_pixel(8'd85,  8'd0,   8'd255, 0, 0);
        queue_pixel(8'd170, 8'd1,   8'd1,   0, 0);
        queue_pixel(8'd64,  8'd128, 8'd128, 0, 0);
        queue_pixel(8'd191, 8'd254, 8'd254, 0, 0);
        queue_pixel(8'h55,  8'hAA,  8'h55,  0, 0);
        queue_pixel(8'hAA,  8'h55,  8'hAA,  0, 0);
        queue_pause();

        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < PhaseItems; n++)
                queue_pixel(pick_byte(), pick_byte(), pick_byte(),
                            idle_mode[ph], stall_mode[ph]);
            queue_pause();
        end
    end

    // Driver: hold an unaccepted beat, otherwise insert a gap or present the next pixel.
    always @(negedge i_clk) begin : hsv_driver
        t_hsv_beat bt;
        bit        send;
        send = 1'b0;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
            if (i_valid && !in_beat_taken) begin
                send = 1'b1;
            end else begin
                if (drain_hold && rgb_expect_q.size() == 0)
                    drain_hold = 1'b0;
                while (!drain_hold && hsv_pending_q.size() != 0 && hsv_pending_q[0].pause) begin
                    void'(hsv_pending_q.pop_front());
                    drain_hold = 1'b1;
                end
                if (!drain_hold && hsv_pending_q.size() != 0 &&
                    $urandom_range(99) >= hsv_pending_q[0].idle_pct) begin
                    bt = hsv_pending_q.pop_front();
                    stall_pct = bt.stall_pct;
                    i_hue_in <= bt.hue;
                    i_sat_in <= bt.sat;
                    i_val_in <= bt.val;
                    send = 1'b1;
                end
            end
        end
        i_valid <= send;
    end

    // Monitor: check delivered pixels in order, predict each accepted input beat.
    always @(posedge i_clk) begin : rgb_monitor
        t_rgb_pixel want;
        in_beat_taken <= i_valid && o_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (rgb_expect_q.size() == 0) begin
                    report_mismatch("unexpected output beat", o_red_out, -1);
                end else begin
                    want = rgb_expect_q.pop_front();
                    if (o_red_out !== want.red)
                        report_mismatch("red_out", o_red_out, want.red);
                    if (o_green_out !== want.green)
                        report_mismatch("green_out", o_green_out, want.green);
                    if (o_blue_out !== want.blue)
                        report_mismatch("blue_out", o_blue_out, want.blue);
                end
            end
            if (i_valid && o_ready)
                rgb_expect_q.push_back(hsv_pixel_color(i_hue_in, i_sat_in, i_val_in));
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : end_of_test
        wait (i_rst_n);
        @(posedge i_clk);
        while (hsv_pending_q.size() != 0 || i_valid || rgb_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DrainCyc) @(posedge i_clk);
        if (mismatch_count == 0 && rgb_expect_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
